### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle property");

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle property");

`endif

### hw/rtl/kse_pkg.sv
// ----------------------------------------------------------------------------
// kse_pkg
// Shared constants, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kse_pkg;

   // Field and bus widths
   localparam int CFG_W  = 6;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;
   localparam int OUT_W  = 32;

   // Default sizing
   localparam int DEF_MAX_POOL   = 32;
   localparam int DEF_MAX_CHOOSE = 32;

   // Register select (byte address bit 2)
   typedef enum logic [0:0] {
      REG_POOL_SIZE   = 1'b0,
      REG_CHOOSE_SIZE = 1'b1
   } reg_idx_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;       // latch n and r, prepare fill from position 0
      logic scan_start;  // load scan pointer with r
      logic scan;        // issue next index read, right to left
      logic advance;     // bump found index, trim mask, prepare fill
      logic fill;        // write one index and set its mask bit
      logic load_out;    // load the result register
      logic load_vs;     // result carries a subset
   } kse_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic r_zero;
      logic r_gt_n;
      logic found;       // compared index is below its maximum
      logic none_left;   // last index compared was at its maximum
      logic fill_done;
   } kse_stat_type;

endpackage

### hw/rtl/kse_csr.sv
// ----------------------------------------------------------------------------
// kse_csr
// Configuration register file: pool size and choose size.
// ----------------------------------------------------------------------------
module kse_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [kse_pkg::ADDR_W-1:0]  paddr,
   input  logic [kse_pkg::DATA_W-1:0]  pwdata,
   output logic [kse_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output logic [kse_pkg::CFG_W-1:0]   pool_size,
   output logic [kse_pkg::CFG_W-1:0]   choose_size
);
   import kse_pkg::*;

   logic [CFG_W-1:0] pool_size_ff, pool_size_in;
   logic [CFG_W-1:0] choose_size_ff, choose_size_in;
   logic             wr_en;
   reg_idx_type      reg_sel;

   assign reg_sel = reg_idx_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Write decode
   always_comb begin
      pool_size_in   = pool_size_ff;
      choose_size_in = choose_size_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_POOL_SIZE:   pool_size_in   = pwdata[CFG_W-1:0];
            REG_CHOOSE_SIZE: choose_size_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_sel)
         REG_POOL_SIZE:   prdata = DATA_W'(pool_size_ff);
         REG_CHOOSE_SIZE: prdata = DATA_W'(choose_size_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff   <= '0;
         choose_size_ff <= '0;
      end else begin
         pool_size_ff   <= pool_size_in;
         choose_size_ff <= choose_size_in;
      end
   end

   assign pool_size   = pool_size_ff;
   assign choose_size = choose_size_ff;

endmodule

### hw/rtl/kse_ctrl.sv
// ----------------------------------------------------------------------------
// kse_ctrl
// Sequencer: request decode, index scan, refill and result hand-off.
// ----------------------------------------------------------------------------
module kse_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_restart,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kse_pkg::kse_cmd_type  cmd,
   input  kse_pkg::kse_stat_type stat
);
   import kse_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_FILL,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      first_ff, first_in;
   logic      exh_ff, exh_in;
   logic      res_vs_ff, res_vs_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      exh_in       = exh_ff;
      res_vs_in    = res_vs_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  cmd.latch = 1'b1;
                  state_in  = ST_START;
               end else if (exh_ff) begin
                  res_vs_in = 1'b0;
                  state_in  = ST_FINISH;
               end else if (first_ff) begin
                  // initial subset is already in the mask
                  first_in  = 1'b0;
                  res_vs_in = 1'b1;
                  state_in  = ST_FINISH;
               end else if (stat.r_zero) begin
                  // empty set was given once, nothing follows
                  exh_in    = 1'b1;
                  res_vs_in = 1'b0;
                  state_in  = ST_FINISH;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_START: begin
            first_in  = 1'b1;
            res_vs_in = 1'b0;
            if (stat.r_gt_n) begin
               exh_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               exh_in   = 1'b0;
               state_in = ST_FILL;
            end
         end
         ST_SCAN: begin
            if (stat.found) begin
               cmd.advance = 1'b1;
               res_vs_in   = 1'b1;
               state_in    = ST_FILL;
            end else if (stat.none_left) begin
               exh_in    = 1'b1;
               res_vs_in = 1'b0;
               state_in  = ST_FINISH;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_FILL: begin
            if (stat.fill_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.fill = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.load_vs = res_vs_ff;
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         exh_ff       <= 1'b1;
         res_vs_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         exh_ff       <= exh_in;
         res_vs_ff    <= res_vs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/kse_dp.sv
// ----------------------------------------------------------------------------
// kse_dp
// Datapath: held n and r, index memory, scan compare, subset mask, result.
// ----------------------------------------------------------------------------
module kse_dp #(
   parameter int MAX_POOL   = kse_pkg::DEF_MAX_POOL,
   parameter int MAX_CHOOSE = kse_pkg::DEF_MAX_CHOOSE
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [kse_pkg::CFG_W-1:0]  pool_size,
   input  logic [kse_pkg::CFG_W-1:0]  choose_size,
   input  kse_pkg::kse_cmd_type       cmd,
   output kse_pkg::kse_stat_type      stat,
   output logic [kse_pkg::OUT_W-1:0]  subset_mask,
   output logic                       valid_subset
);
   import kse_pkg::*;

   localparam int N_W    = $clog2(MAX_POOL + 1);
   localparam int R_W    = $clog2(MAX_CHOOSE + 1);
   localparam int IDX_W  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
   localparam int ADR_W  = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
   localparam int SUM_W  = ((N_W > R_W) ? N_W : R_W) + 1;
   localparam int MASK_W = (MAX_POOL > OUT_W) ? MAX_POOL : OUT_W;
   localparam int LIM_W  = CFG_W + 1;
   localparam logic [LIM_W-1:0] POOL_LIM   = LIM_W'(MAX_POOL);
   localparam logic [LIM_W-1:0] CHOOSE_LIM = LIM_W'(MAX_CHOOSE);

   // Index memory
   logic [IDX_W-1:0] idx_mem [MAX_CHOOSE];

   logic [N_W-1:0]    held_n_ff, held_n_in;
   logic [R_W-1:0]    held_r_ff, held_r_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [R_W-1:0]    ptr_ff, ptr_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [ADR_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [IDX_W-1:0]  rd_data_ff;
   logic [R_W-1:0]    fill_pos_ff, fill_pos_in;
   logic [IDX_W-1:0]  fill_val_ff, fill_val_in;
   logic [OUT_W-1:0]  out_mask_ff, out_mask_in;
   logic              out_vs_ff, out_vs_in;

   logic [LIM_W-1:0]  n_cfg, r_cfg, n_lim, r_lim;
   logic [R_W-1:0]    ptr_m1;
   logic [ADR_W-1:0]  rd_addr, wr_addr;
   logic              issue;
   logic              at_max;
   logic [MASK_W-1:0] mask_keep;
   logic [MASK_W-1:0] set_bit;

   // Saturate configuration at latch time
   assign n_cfg = {1'b0, pool_size};
   assign r_cfg = {1'b0, choose_size};
   assign n_lim = (n_cfg > POOL_LIM) ? POOL_LIM : n_cfg;
   assign r_lim = (r_cfg > CHOOSE_LIM) ? CHOOSE_LIM : r_cfg;

   // Scan addressing, right to left
   assign ptr_m1  = ptr_ff - 1'b1;
   assign rd_addr = ptr_m1[ADR_W-1:0];
   assign wr_addr = fill_pos_ff[ADR_W-1:0];
   assign issue   = cmd.scan && (ptr_ff != '0);

   // Index i is at its maximum when idx + r == i + n
   assign at_max = (SUM_W'(rd_data_ff) + SUM_W'(held_r_ff)) ==
                   (SUM_W'(rd_pos_ff) + SUM_W'(held_n_ff));

   // Drop the bumped index and every position above it
   always_comb begin
      for (int k = 0; k < MASK_W; k++) begin
         mask_keep[k] = mask_ff[k] && (k < int'(rd_data_ff));
      end
   end

   assign set_bit = MASK_W'(1) << fill_val_ff;

   // Next values
   always_comb begin
      held_n_in   = held_n_ff;
      held_r_in   = held_r_ff;
      mask_in     = mask_ff;
      ptr_in      = ptr_ff;
      rd_valid_in = rd_valid_ff;
      rd_pos_in   = rd_pos_ff;
      fill_pos_in = fill_pos_ff;
      fill_val_in = fill_val_ff;
      out_mask_in = out_mask_ff;
      out_vs_in   = out_vs_ff;

      if (cmd.latch) begin
         held_n_in   = n_lim[N_W-1:0];
         held_r_in   = r_lim[R_W-1:0];
         mask_in     = '0;
         fill_pos_in = '0;
         fill_val_in = '0;
      end
      if (cmd.scan_start) begin
         ptr_in      = held_r_ff;
         rd_valid_in = 1'b0;
      end
      if (issue) begin
         ptr_in      = ptr_m1;
         rd_valid_in = 1'b1;
         rd_pos_in   = rd_addr;
      end
      if (cmd.advance) begin
         mask_in     = mask_keep;
         fill_pos_in = R_W'(rd_pos_ff);
         fill_val_in = rd_data_ff + 1'b1;
         rd_valid_in = 1'b0;
      end
      if (cmd.fill) begin
         mask_in     = mask_ff | set_bit;
         fill_pos_in = fill_pos_ff + 1'b1;
         fill_val_in = fill_val_ff + 1'b1;
      end
      if (cmd.load_out) begin
         out_mask_in = cmd.load_vs ? mask_ff[OUT_W-1:0] : '0;
         out_vs_in   = cmd.load_vs;
      end
   end

   // Memory write port and registered read port
   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         idx_mem[wr_addr] <= fill_val_ff;
      end
      if (issue) begin
         rd_data_ff <= idx_mem[rd_addr];
      end
   end

   // Control flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      held_n_ff   <= held_n_in;
      held_r_ff   <= held_r_in;
      mask_ff     <= mask_in;
      ptr_ff      <= ptr_in;
      rd_pos_ff   <= rd_pos_in;
      fill_pos_ff <= fill_pos_in;
      fill_val_ff <= fill_val_in;
      out_mask_ff <= out_mask_in;
      out_vs_ff   <= out_vs_in;
   end

   // Status to the sequencer
   always_comb begin
      stat.r_zero    = (held_r_ff == '0);
      stat.r_gt_n    = SUM_W'(held_r_ff) > SUM_W'(held_n_ff);
      stat.found     = rd_valid_ff && !at_max;
      stat.none_left = rd_valid_ff && at_max && (ptr_ff == '0);
      stat.fill_done = (fill_pos_ff == held_r_ff);
   end

   assign subset_mask  = out_mask_ff;
   assign valid_subset = out_vs_ff;

endmodule

### hw/rtl/k_subset_lex_enumerator_unit.sv
// ----------------------------------------------------------------------------
// k_subset_lex_enumerator_unit
// Walks the r-element subsets of an n-element pool in lexicographic order
// of sorted indices and returns each one as a pool position bit mask.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------
//   req      | in        | req_valid / req_stall | req_restart
//   rsp      | out       | rsp_valid / rsp_stall | rsp_subset_mask, rsp_valid_subset
//   csr      | in/out    | psel/penable/pready   | pool_size (0x0), choose_size (0x4)
//
// One transaction at a time. Restart: latch n and r, then refill the index
// memory (one index written per cycle), then the result. Next: a right-to-left
// scan through the single read port of the index memory, then the refill
// through its write port; exhausted or first requests go straight to the result.
// The result register frees the input side: a new transaction is taken while
// the previous result is still stalled. Synchronous reset leaves the unit
// exhausted until the first restart.
// ----------------------------------------------------------------------------
module k_subset_lex_enumerator_unit #(
   parameter int MAX_POOL   = kse_pkg::DEF_MAX_POOL,
   parameter int MAX_CHOOSE = kse_pkg::DEF_MAX_CHOOSE
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_restart,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [kse_pkg::OUT_W-1:0]   rsp_subset_mask,
   output logic                        rsp_valid_subset,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [kse_pkg::ADDR_W-1:0]  paddr,
   input  logic [kse_pkg::DATA_W-1:0]  pwdata,
   output logic [kse_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import kse_pkg::*;

   logic [CFG_W-1:0] pool_size;
   logic [CFG_W-1:0] choose_size;
   kse_cmd_type      cmd;
   kse_stat_type     stat;

   // Configuration registers
   kse_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .pool_size   (pool_size),
      .choose_size (choose_size)
   );

   // Sequencer
   kse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .stat        (stat)
   );

   // Datapath
   kse_dp #(
      .MAX_POOL   (MAX_POOL),
      .MAX_CHOOSE (MAX_CHOOSE)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .pool_size    (pool_size),
      .choose_size  (choose_size),
      .cmd          (cmd),
      .stat         (stat),
      .subset_mask  (rsp_subset_mask),
      .valid_subset (rsp_valid_subset)
   );

endmodule

### hw/rtl/kse_checker.sv
// ----------------------------------------------------------------------------
// kse_checker
// Port-level checks on the enumerator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kse_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [kse_pkg::OUT_W-1:0]  rsp_subset_mask,
   input logic                       rsp_valid_subset
);

   // A stalled result transaction stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled result payload does not move
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_subset_mask) && $stable(rsp_valid_subset))

   // No subset means an empty mask
   `ASSERT_SAME(a_empty_mask, clock, reset, rsp_valid && !rsp_valid_subset, rsp_subset_mask == '0)

   // Unit is busy in the cycle after taking a request
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind k_subset_lex_enumerator_unit kse_checker u_kse_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_subset_mask  (rsp_subset_mask),
   .rsp_valid_subset (rsp_valid_subset)
);
